/* rtl/skf_pkg.sv */
`timescale 1ns / 1ps
package skf_pkg;

  localparam int REG_W    = 32;   // covariance, noise and estimate width
  localparam int FRAC_W   = 16;   // gain fraction bits, estimate fraction bits
  localparam int CNT_W    = $clog2(FRAC_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [REG_W-1:0]  COV_ONE  = 32'd268435456;  // 1.0 in Q4.28
  localparam logic [REG_W-1:0]  R_RESET  = 32'd2684355;    // 0.01 in Q4.28
  localparam logic [FRAC_W-1:0] GAIN_MAX = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRED,
    S_DEN,
    S_DIV,
    S_ERR,
    S_MULE,
    S_UPD,
    S_MULP,
    S_COV,
    S_DONE
  } state_t;

  typedef struct packed {
    state_t step;
    logic   last;
    logic   in_ready;
    logic   take;
    logic   load;
  } ctrl_t;

endpackage

/* rtl/skf_sample_if.sv */
`timescale 1ns / 1ps
interface skf_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/skf_estimate_if.sv */
`timescale 1ns / 1ps
interface skf_estimate_if;
  import skf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [REG_W-1:0] estimate;

  modport source (output valid, output estimate, input ready);
  modport sink   (input valid, input estimate, output ready);
endinterface

/* rtl/scalar_kalman_filter_unit.sv */
`timescale 1ns / 1ps
// channel     | dir | payload                    | transaction when
// ------------+-----+----------------------------+----------------------
// samples     | in  | sample  (SAMPLE_WIDTH, s)  | valid && ready
// estimates   | out | estimate (32, s, Q16.16)   | valid && ready
// cfg_*       | in  | index 0 Q, 1 R (32, u)     | cfg_we high
//
// one shared adder (50 bits at the default width) steps through predict,
// 16 divide steps, 16 multiply steps for the estimate and 16 for the covariance
// ready only in idle; the finished result sits in an output register,
// and the block waits in its last step while that register is still held
// synchronous reset: estimate 0, covariance 1.0, Q 0, R 0.01
module scalar_kalman_filter_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  skf_sample_if.sink                    samples,
  skf_estimate_if.source                estimates,
  input  logic                          cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skf_pkg::REG_W-1:0]     cfg_data
);
  import skf_pkg::*;

  // error = sample*2^16 - estimate, product = gain * error
  localparam int ERR_W  = ((SAMPLE_WIDTH > FRAC_W) ? SAMPLE_WIDTH : FRAC_W) + FRAC_W + 1;
  localparam int PROD_W = ERR_W + FRAC_W;
  localparam int COVP_W = REG_W + FRAC_W + 1;
  localparam int AW     = ((PROD_W > COVP_W) ? PROD_W : COVP_W) + 1;

  ctrl_t ctrl;

  // configuration registers
  logic [REG_W-1:0] process_noise;
  logic [REG_W-1:0] measure_noise;

  // filter state
  logic [REG_W-1:0] estimate_reg;
  logic [REG_W-1:0] covariance_reg;

  // per-sample working registers
  logic [SAMPLE_WIDTH-1:0] smp;
  logic [REG_W-1:0]        pred;
  logic [REG_W:0]          den;
  logic [FRAC_W-1:0]       gain;
  logic [FRAC_W-1:0]       mplier;
  logic [ERR_W-1:0]        err;
  logic [AW-1:0]           acc;   // divide remainder, then product accumulator

  // output register
  logic             out_valid;
  logic [REG_W-1:0] out_data;

  // shared adder
  logic [AW-1:0] op_a;
  logic [AW-1:0] op_b;
  logic          op_sub;
  logic [AW-1:0] sum;

  logic [AW-1:0]    acc_shl;
  logic [AW-1:0]    err_ext;
  logic [AW-1:0]    est_ext;
  logic [AW-1:0]    pred_ext;
  logic             fits32;
  logic [REG_W-1:0] est_sat;
  logic             qbit;

  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .out_busy (out_valid && !estimates.ready),
    .ctrl     (ctrl)
  );

  skf_addsub #(.W(AW)) u_addsub (
    .a   (op_a),
    .b   (op_b),
    .sub (op_sub),
    .sum (sum)
  );

  assign samples.ready      = ctrl.in_ready;
  assign estimates.valid    = out_valid;
  assign estimates.estimate = out_data;

  assign acc_shl  = {acc[AW-2:0], 1'b0};
  assign err_ext  = {{(AW-ERR_W){err[ERR_W-1]}}, err};
  assign est_ext  = {{(AW-REG_W){estimate_reg[REG_W-1]}}, estimate_reg};
  assign pred_ext = {{(AW-REG_W){1'b0}}, pred};

  // quotient bit: shifted remainder minus divisor stayed non-negative
  assign qbit = !sum[AW-1];

  // estimate saturation to the signed 32-bit range
  assign fits32  = (&sum[AW-1:REG_W-1]) || !(|sum[AW-1:REG_W-1]);
  assign est_sat = fits32 ? sum[REG_W-1:0]
                          : (sum[AW-1] ? {1'b1, {(REG_W-1){1'b0}}}
                                       : {1'b0, {(REG_W-1){1'b1}}});

  // operand selection per step
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    case (ctrl.step)
      S_PRED: begin
        op_a = {{(AW-REG_W){1'b0}}, covariance_reg};
        op_b = {{(AW-REG_W){1'b0}}, process_noise};
      end
      S_DEN: begin
        op_a = pred_ext;
        op_b = {{(AW-REG_W){1'b0}}, measure_noise};
      end
      S_DIV: begin
        op_a   = acc_shl;
        op_b   = {{(AW-REG_W-1){1'b0}}, den};
        op_sub = 1'b1;
      end
      S_ERR: begin
        op_a   = {{(AW-SAMPLE_WIDTH-FRAC_W){smp[SAMPLE_WIDTH-1]}}, smp, {FRAC_W{1'b0}}};
        op_b   = est_ext;
        op_sub = 1'b1;
      end
      S_MULE: begin
        op_a = acc_shl;
        op_b = mplier[FRAC_W-1] ? err_ext : '0;
      end
      S_UPD: begin
        // arithmetic shift gives the floor of the scaled product
        op_a = est_ext;
        op_b = {{FRAC_W{acc[AW-1]}}, acc[AW-1:FRAC_W]};
      end
      S_MULP: begin
        op_a = acc_shl;
        op_b = mplier[FRAC_W-1] ? pred_ext : '0;
      end
      S_COV: begin
        // (1 - gain) * pred = pred*2^16 - gain*pred
        op_a   = {{(AW-REG_W-FRAC_W){1'b0}}, pred, {FRAC_W{1'b0}}};
        op_b   = acc;
        op_sub = 1'b1;
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        op_sub = 1'b0;
      end
    endcase
  end

  // configuration writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= '0;
      measure_noise <= R_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE: process_noise <= cfg_data;
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_reg   <= '0;
      covariance_reg <= COV_ONE;
    end else begin
      if (ctrl.step == S_UPD) estimate_reg   <= est_sat;
      if (ctrl.step == S_COV) covariance_reg <= sum[REG_W+FRAC_W-1:FRAC_W];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.take) smp <= samples.sample;
    case (ctrl.step)
      S_PRED: pred <= sum[REG_W] ? {REG_W{1'b1}} : sum[REG_W-1:0];
      S_DEN: begin
        den  <= sum[REG_W:0];
        acc  <= pred_ext;
        gain <= '0;
      end
      S_DIV: begin
        acc <= qbit ? sum : acc_shl;
        if (ctrl.last) begin
          // zero denominator gives zero gain, R of zero saturates the gain
          if (den == '0)                 gain <= '0;
          else if (measure_noise == '0)  gain <= GAIN_MAX;
          else                           gain <= {gain[FRAC_W-2:0], qbit};
        end else begin
          gain <= {gain[FRAC_W-2:0], qbit};
        end
      end
      S_ERR: begin
        err    <= sum[ERR_W-1:0];
        acc    <= '0;
        mplier <= gain;
      end
      S_MULE, S_MULP: begin
        acc    <= sum;
        mplier <= {mplier[FRAC_W-2:0], 1'b0};
      end
      S_UPD: begin
        acc    <= '0;
        mplier <= gain;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (estimates.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) out_data <= estimate_reg;
  end
endmodule

/* rtl/skf_addsub.sv */
`timescale 1ns / 1ps
module skf_addsub #(
  parameter int W = 58
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum
);
  logic [W-1:0] b_eff;

  // two's complement subtract via inverted operand and carry in
  assign b_eff = sub ? ~b : b;
  assign sum   = a + b_eff + W'(sub);
endmodule

/* rtl/skf_ctrl.sv */
`timescale 1ns / 1ps
module skf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_busy,
  output skf_pkg::ctrl_t ctrl
);
  import skf_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             loop_step;
  logic             last;

  assign loop_step = (state == S_DIV) || (state == S_MULE) || (state == S_MULP);
  assign last      = &cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      // counter wraps back to zero after the last step of each loop
      if (loop_step) cnt <= cnt + 1'b1;
      else           cnt <= '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_PRED;
      S_PRED:  state_next = S_DEN;
      S_DEN:   state_next = S_DIV;
      S_DIV:   if (last) state_next = S_ERR;
      S_ERR:   state_next = S_MULE;
      S_MULE:  if (last) state_next = S_UPD;
      S_UPD:   state_next = S_MULP;
      S_MULP:  if (last) state_next = S_COV;
      S_COV:   state_next = S_DONE;
      S_DONE:  if (!out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.step     = state;
    ctrl.last     = last;
    ctrl.in_ready = (state == S_IDLE);
    ctrl.take     = (state == S_IDLE) && in_valid;
    ctrl.load     = (state == S_DONE) && !out_busy;
  end
endmodule
